### src/crc_pkg.sv
// shared register map and configuration port constants for the collision resolver
`timescale 1ns / 1ps
package crc_pkg;

   // configuration port address width
   localparam int CSR_ADDR_BITS = 8;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_MIN_X  = 8'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_MIN_Y  = 8'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_WIDTH  = 8'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_HEIGHT = 8'd3;

endpackage

### src/crc_csr.sv
// rectangle configuration registers
`timescale 1ns / 1ps
module crc_csr import crc_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [COORD_BITS-1:0]        csr_wdata,
   output logic signed [COORD_BITS-1:0] rect_min_x,
   output logic signed [COORD_BITS-1:0] rect_min_y,
   output logic [COORD_BITS-2:0]        rect_width,
   output logic [COORD_BITS-2:0]        rect_height
);

   logic signed [COORD_BITS-1:0] min_x_ff, min_y_ff;
   logic [COORD_BITS-2:0]        width_ff, height_ff;
   logic                         wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff  <= '0;
         min_y_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (wr) begin
         case (csr_addr)
            REG_MIN_X:  min_x_ff  <= csr_wdata;
            REG_MIN_Y:  min_y_ff  <= csr_wdata;
            REG_WIDTH:  width_ff  <= csr_wdata[COORD_BITS-2:0];
            REG_HEIGHT: height_ff <= csr_wdata[COORD_BITS-2:0];
            default: ;
         endcase
      end
   end

   assign rect_min_x  = min_x_ff;
   assign rect_min_y  = min_y_ff;
   assign rect_width  = width_ff;
   assign rect_height = height_ff;

endmodule

### src/crc_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module crc_sqrt #(
   parameter int OUT_BITS = 33,
   parameter int PAY_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2*OUT_BITS-1:0] in_value,
   input  logic [PAY_BITS-1:0]   in_pay,
   output logic                  out_valid,
   output logic [OUT_BITS-1:0]   out_root,
   output logic [PAY_BITS-1:0]   out_pay
);

   localparam int IB = 2 * OUT_BITS;
   localparam int RB = OUT_BITS + 3;

   logic                valid_ff [0:OUT_BITS];
   logic [IB-1:0]       num_ff   [0:OUT_BITS];
   logic [RB-1:0]       rem_ff   [0:OUT_BITS];
   logic [OUT_BITS-1:0] root_ff  [0:OUT_BITS];
   logic [PAY_BITS-1:0] pay_ff   [0:OUT_BITS];

   // stage zero is the input
   always_comb begin
      valid_ff[0] = in_valid;
      num_ff[0]   = in_value;
      rem_ff[0]   = '0;
      root_ff[0]  = '0;
      pay_ff[0]   = in_pay;
   end

   for (genvar k = 0; k < OUT_BITS; k++) begin : g_stage
      logic [RB-1:0]       rem_sh, trial, rem_in;
      logic [OUT_BITS-1:0] root_in;
      logic                take;

      // bring down two bits, try root*4+1
      always_comb begin
         rem_sh  = {rem_ff[k][RB-3:0], num_ff[k][IB-1:IB-2]};
         trial   = {1'b0, root_ff[k], 2'b01};
         take    = rem_sh >= trial;
         rem_in  = take ? rem_sh - trial : rem_sh;
         root_in = {root_ff[k][OUT_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[k+1] <= 1'b0;
         else       valid_ff[k+1] <= valid_ff[k];
         num_ff[k+1]  <= {num_ff[k][IB-3:0], 2'b00};
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         pay_ff[k+1]  <= pay_ff[k];
      end
   end

   assign out_valid = valid_ff[OUT_BITS];
   assign out_root  = root_ff[OUT_BITS];
   assign out_pay   = pay_ff[OUT_BITS];

   // remainder never exceeds twice the root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> rem_ff[OUT_BITS] <= {1'b0, root_ff[OUT_BITS], 1'b0})
      else $error("sqrt remainder above twice the root");

endmodule

### src/crc_div.sv
// two-lane pipelined restoring divider sharing one divisor
`timescale 1ns / 1ps
module crc_div #(
   parameter int QUO_BITS = 32,
   parameter int DEN_BITS = 33,
   parameter int PAY_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [DEN_BITS+QUO_BITS-1:0] in_num_a,
   input  logic [DEN_BITS+QUO_BITS-1:0] in_num_b,
   input  logic [DEN_BITS-1:0]          in_den,
   input  logic [PAY_BITS-1:0]          in_pay,
   output logic                         out_valid,
   output logic [QUO_BITS-1:0]          out_quo_a,
   output logic [QUO_BITS-1:0]          out_quo_b,
   output logic [PAY_BITS-1:0]          out_pay
);

   localparam int QB = QUO_BITS;
   localparam int DB = DEN_BITS;

   logic          valid_ff [0:QB];
   logic [DB-1:0] den_ff   [0:QB];
   logic [DB-1:0] rem_a_ff [0:QB];
   logic [DB-1:0] rem_b_ff [0:QB];
   logic [QB-1:0] low_a_ff [0:QB];
   logic [QB-1:0] low_b_ff [0:QB];
   logic [QB-1:0] quo_a_ff [0:QB];
   logic [QB-1:0] quo_b_ff [0:QB];
   logic [PAY_BITS-1:0] pay_ff [0:QB];

   // high part of the numerator starts as the partial remainder
   always_comb begin
      valid_ff[0] = in_valid;
      den_ff[0]   = in_den;
      rem_a_ff[0] = in_num_a[DB+QB-1:QB];
      rem_b_ff[0] = in_num_b[DB+QB-1:QB];
      low_a_ff[0] = in_num_a[QB-1:0];
      low_b_ff[0] = in_num_b[QB-1:0];
      quo_a_ff[0] = '0;
      quo_b_ff[0] = '0;
      pay_ff[0]   = in_pay;
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [DB:0]   sh_a, sh_b, dd;
      logic          ta, tb;
      logic [DB-1:0] ra_in, rb_in;

      // shift in one bit and subtract when it fits
      always_comb begin
         dd    = {1'b0, den_ff[k]};
         sh_a  = {rem_a_ff[k], low_a_ff[k][QB-1]};
         sh_b  = {rem_b_ff[k], low_b_ff[k][QB-1]};
         ta    = sh_a >= dd;
         tb    = sh_b >= dd;
         ra_in = ta ? DB'(sh_a - dd) : sh_a[DB-1:0];
         rb_in = tb ? DB'(sh_b - dd) : sh_b[DB-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[k+1] <= 1'b0;
         else       valid_ff[k+1] <= valid_ff[k];
         den_ff[k+1]   <= den_ff[k];
         rem_a_ff[k+1] <= ra_in;
         rem_b_ff[k+1] <= rb_in;
         low_a_ff[k+1] <= low_a_ff[k] << 1;
         low_b_ff[k+1] <= low_b_ff[k] << 1;
         quo_a_ff[k+1] <= {quo_a_ff[k][QB-2:0], ta};
         quo_b_ff[k+1] <= {quo_b_ff[k][QB-2:0], tb};
         pay_ff[k+1]   <= pay_ff[k];
      end
   end

   assign out_valid = valid_ff[QB];
   assign out_quo_a = quo_a_ff[QB];
   assign out_quo_b = quo_b_ff[QB];
   assign out_pay   = pay_ff[QB];

   // final remainders stay below a nonzero divisor
   a_rem_a: assert property (@(posedge clock) disable iff (reset)
      (out_valid && den_ff[QB] != '0) |-> rem_a_ff[QB] < den_ff[QB])
      else $error("divider lane a remainder not below divisor");
   a_rem_b: assert property (@(posedge clock) disable iff (reset)
      (out_valid && den_ff[QB] != '0) |-> rem_b_ff[QB] < den_ff[QB])
      else $error("divider lane b remainder not below divisor");

endmodule

### src/circle_rect_collide_resolve.sv
// top level: circle against rectangle collision test and push-out
`timescale 1ns / 1ps
// Circle against axis-aligned rectangle collision resolver, signed fixed point.
// Request channel: pos_x, pos_y, radius are taken at a clock edge with start
// high and busy low. busy stays low, so one particle can enter every cycle.
// Response channel: rsp_valid pulses for one cycle with collides, out_x and
// out_y. The receiver cannot stall; every response is taken as it appears.
// Pipeline: input register, clamp, multiply, sum and compare, a COORD_BITS+1
// stage square root and a COORD_BITS stage divider, then the final add with
// saturation.
// Throughput is one particle per cycle; the depth is set by the bit-serial
// square root and divider pipelines.
// Configuration: csr_valid/csr_ready write channel, csr_addr selects
// rect_min_x, rect_min_y, rect_width, rect_height (indexes 0..3); other
// indexes are ignored. Write only while no particle is in flight.
// Reset (synchronous, active high) clears the rectangle to zero and empties
// the pipeline.
module circle_rect_collide_resolve import crc_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic [COORD_BITS-2:0]        req_radius,
   output logic                         rsp_valid,
   output logic                         rsp_collides,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [COORD_BITS-1:0]        csr_wdata
);

   localparam int C  = COORD_BITS;
   localparam int WB = C + 3;
   localparam longint unsigned EPS_L  = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam longint unsigned EPS2_L =
      ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
   localparam logic [C-1:0]     EPS    = C'(EPS_L);
   localparam logic [2*C+1:0]   EPS2   = (2*C+2)'(EPS2_L);
   localparam logic signed [WB-1:0] SMAX = WB'((longint'(1) << (C - 1)) - 1);
   localparam logic signed [WB-1:0] SMIN = -SMAX - WB'(1);

   typedef struct packed {
      logic                collides;
      logic                outside;
      logic                neg_x;
      logic                neg_y;
      logic signed [WB-1:0] cx;
      logic signed [WB-1:0] cy;
      logic [C-1:0]        in_x;
      logic [C-1:0]        in_y;
   } res_type;

   typedef struct packed {
      res_type     res;
      logic [2*C:0] num_x;
      logic [2*C:0] num_y;
   } root_pay_type;

   function automatic logic [C-1:0] sat(input logic signed [WB-1:0] v);
      if (v > SMAX)      sat = SMAX[C-1:0];
      else if (v < SMIN) sat = SMIN[C-1:0];
      else               sat = v[C-1:0];
   endfunction

   logic signed [C-1:0] rect_min_x, rect_min_y;
   logic [C-2:0]        rect_width, rect_height;

   crc_csr #(.COORD_BITS(C)) u_csr (
      .clock, .reset, .csr_valid, .csr_ready, .csr_addr, .csr_wdata,
      .rect_min_x, .rect_min_y, .rect_width, .rect_height
   );

   assign busy = 1'b0;

   // stage 0: input register
   logic                v0_ff;
   logic signed [C-1:0] px0_ff, py0_ff;
   logic [C-2:0]        r0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start && !busy;
      px0_ff <= req_pos_x;
      py0_ff <= req_pos_y;
      r0_ff  <= req_radius;
   end

   // stage 1: clamp to the box, offsets and edge distances
   logic signed [WB-1:0] minx, miny, maxx, maxy, px, py, cx, cy, dx, dy;
   logic signed [WB-1:0] el, er, et, eb;
   logic                 v1_ff;
   logic signed [WB-1:0] px1_ff, py1_ff, minx1_ff, miny1_ff, maxx1_ff, maxy1_ff;
   logic signed [WB-1:0] cx1_ff, cy1_ff;
   logic [C:0]           ax1_ff, ay1_ff;
   logic                 nx1_ff, ny1_ff;
   logic [C-2:0]         r1_ff;
   logic [C-1:0]         re1_ff;
   logic [C+1:0]         dl1_ff, dr1_ff, dt1_ff, db1_ff;

   always_comb begin
      minx = WB'(rect_min_x);
      miny = WB'(rect_min_y);
      maxx = minx + $signed({3'b000, rect_width});
      maxy = miny + $signed({3'b000, rect_height});
      px   = WB'(px0_ff);
      py   = WB'(py0_ff);
      cx   = (px < minx) ? minx : ((px > maxx) ? maxx : px);
      cy   = (py < miny) ? miny : ((py > maxy) ? maxy : py);
      dx   = px - cx;
      dy   = py - cy;
      el   = px - minx;
      er   = maxx - px;
      et   = py - miny;
      eb   = maxy - py;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
      px1_ff   <= px;
      py1_ff   <= py;
      minx1_ff <= minx;
      miny1_ff <= miny;
      maxx1_ff <= maxx;
      maxy1_ff <= maxy;
      cx1_ff   <= cx;
      cy1_ff   <= cy;
      ax1_ff   <= dx[WB-1] ? (C+1)'(-dx) : dx[C:0];
      ay1_ff   <= dy[WB-1] ? (C+1)'(-dy) : dy[C:0];
      nx1_ff   <= dx[WB-1];
      ny1_ff   <= dy[WB-1];
      r1_ff    <= r0_ff;
      re1_ff   <= {1'b0, r0_ff} + EPS;
      dl1_ff   <= el[WB-1] ? (C+2)'(-el) : el[C+1:0];
      dr1_ff   <= er[WB-1] ? (C+2)'(-er) : er[C+1:0];
      dt1_ff   <= et[WB-1] ? (C+2)'(-et) : et[C+1:0];
      db1_ff   <= eb[WB-1] ? (C+2)'(-eb) : eb[C+1:0];
   end

   // stage 2: products and nearest-edge push-out
   logic signed [WB-1:0] re_w, in_x, in_y;
   logic                 top_w, bot_w, left_w;
   logic                 v2_ff;
   logic [2*C+1:0]       sqx2_ff, sqy2_ff;
   logic [2*C-3:0]       rr2_ff;
   logic [2*C:0]         numx2_ff, numy2_ff;
   logic signed [WB-1:0] cx2_ff, cy2_ff;
   logic                 nx2_ff, ny2_ff;
   logic [C-1:0]         inx2_ff, iny2_ff;

   always_comb begin
      re_w   = $signed({3'b000, re1_ff});
      top_w  = dt1_ff <= dl1_ff && dt1_ff <= dr1_ff && dt1_ff <= db1_ff;
      bot_w  = db1_ff <= dl1_ff && db1_ff <= dr1_ff;
      left_w = dl1_ff <= dr1_ff;
      in_x   = px1_ff;
      in_y   = py1_ff;
      if (top_w)       in_y = miny1_ff - re_w;
      else if (bot_w)  in_y = maxy1_ff + re_w;
      else if (left_w) in_x = minx1_ff - re_w;
      else             in_x = maxx1_ff + re_w;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      sqx2_ff  <= ax1_ff * ax1_ff;
      sqy2_ff  <= ay1_ff * ay1_ff;
      rr2_ff   <= r1_ff * r1_ff;
      numx2_ff <= ax1_ff * re1_ff;
      numy2_ff <= ay1_ff * re1_ff;
      cx2_ff   <= cx1_ff;
      cy2_ff   <= cy1_ff;
      nx2_ff   <= nx1_ff;
      ny2_ff   <= ny1_ff;
      inx2_ff  <= sat(in_x);
      iny2_ff  <= sat(in_y);
   end

   // stage 3: squared distance, collision flag and case select
   logic [2*C+1:0] d2;
   logic           v3_ff;
   logic [2*C+1:0] d23_ff;
   root_pay_type   pay3_ff;

   assign d2 = sqx2_ff + sqy2_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      d23_ff               <= d2;
      pay3_ff.res.collides <= d2 < {4'b0000, rr2_ff};
      pay3_ff.res.outside  <= d2 > EPS2;
      pay3_ff.res.neg_x    <= nx2_ff;
      pay3_ff.res.neg_y    <= ny2_ff;
      pay3_ff.res.cx       <= cx2_ff;
      pay3_ff.res.cy       <= cy2_ff;
      pay3_ff.res.in_x     <= inx2_ff;
      pay3_ff.res.in_y     <= iny2_ff;
      pay3_ff.num_x        <= numx2_ff;
      pay3_ff.num_y        <= numy2_ff;
   end

   // distance by square root
   logic         vs;
   logic [C:0]   dist_root;
   root_pay_type pays;

   crc_sqrt #(.OUT_BITS(C + 1), .PAY_BITS($bits(root_pay_type))) u_sqrt (
      .clock, .reset,
      .in_valid(v3_ff), .in_value(d23_ff), .in_pay(pay3_ff),
      .out_valid(vs), .out_root(dist_root), .out_pay(pays)
   );

   // offsets scaled by (radius + eps) / distance
   logic         vd;
   logic [C-1:0] offx, offy;
   res_type      resd;

   crc_div #(.QUO_BITS(C), .DEN_BITS(C + 1), .PAY_BITS($bits(res_type))) u_div (
      .clock, .reset,
      .in_valid(vs), .in_num_a(pays.num_x), .in_num_b(pays.num_y),
      .in_den(dist_root), .in_pay(pays.res),
      .out_valid(vd), .out_quo_a(offx), .out_quo_b(offy), .out_pay(resd)
   );

   // final stage: apply offset, saturate, response register
   logic signed [WB-1:0] ofx, ofy, sx, sy;
   logic                 rv_ff, rc_ff;
   logic [C-1:0]         rx_ff, ry_ff;

   always_comb begin
      ofx = $signed({3'b000, offx});
      ofy = $signed({3'b000, offy});
      sx  = resd.neg_x ? resd.cx - ofx : resd.cx + ofx;
      sy  = resd.neg_y ? resd.cy - ofy : resd.cy + ofy;
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= vd;
      rc_ff <= resd.collides;
      rx_ff <= resd.outside ? sat(sx) : resd.in_x;
      ry_ff <= resd.outside ? sat(sy) : resd.in_y;
   end

   assign rsp_valid    = rv_ff;
   assign rsp_collides = rc_ff;
   assign rsp_out_x    = rx_ff;
   assign rsp_out_y    = ry_ff;

   // the outside path never divides by zero
   a_dist_nonzero: assert property (@(posedge clock) disable iff (reset)
      (vs && pays.res.outside) |-> dist_root != '0)
      else $error("outside case reached divider with zero distance");

   // the block never holds off a request
   a_busy_low: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");

   // no response right after a reset cycle
   a_rsp_cleared: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe after reset");

endmodule
